FILE: hw/rtl/dot_pkg.sv
package dot_pkg;

    localparam int CMD_W    = 3;
    localparam int LEN_W    = 16;
    localparam int IDX_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int OUT_W    = 32;
    localparam int IN_OFS_W = 32;
    localparam int CFG_W    = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CMD_W-1:0] CMD_MARK_POINT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MARK_RANGE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MARK_FULL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_INDEX = 3'd5;

    localparam logic REG_MERGE_THR = 1'b0;
    localparam logic REG_RANGE_LIM = 1'b1;

    localparam logic [CFG_W-1:0] MERGE_THR_RST = 16'd64;
    localparam logic [CFG_W-1:0] RANGE_LIM_RST = 16'd1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_NEXT,
        ST_READ,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;         // capture input beat
        logic scan_first;   // start search with the given offset
        logic scan_second;  // start search with the range end
        logic scan_step;    // advance the search walk
        logic insert;       // append point to the table
        logic set_full;     // set full-redraw flag, empty table
        logic clear_all;    // clear flag, empty table
        logic hit_one;
        logic hit_near;
        logic read_sel;     // memory address from read index
        logic read_cap;     // capture read data when the index is valid
        logic out_load;     // move result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             len_zero;
        logic             len_big;
        logic             scan_done;
        logic             near;
        logic             table_full;
    } t_dp_sts;

endpackage

FILE: hw/rtl/dot_dpath.sv
module dot_dpath #(
    parameter int CAPACITY    = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dot_pkg::t_dp_cmd                 i_ctl,
    output dot_pkg::t_dp_sts                 o_sts,
    input  logic [dot_pkg::CMD_W-1:0]        i_cmd,
    input  logic [dot_pkg::IN_OFS_W-1:0]     i_offset,
    input  logic [dot_pkg::LEN_W-1:0]        i_length,
    input  logic [dot_pkg::IDX_W-1:0]        i_index,
    input  logic [dot_pkg::CFG_W-1:0]        i_thr,
    input  logic [dot_pkg::CFG_W-1:0]        i_lim,
    output logic                             o_status,
    output logic                             o_full_redraw,
    output logic [dot_pkg::COUNT_W-1:0]      o_count,
    output logic                             o_hit,
    output logic [dot_pkg::OUT_W-1:0]        o_read_value
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = (OFFSET_BITS > dot_pkg::CFG_W) ? OFFSET_BITS : dot_pkg::CFG_W;
    localparam int XW = (CW > dot_pkg::IDX_W) ? CW : dot_pkg::IDX_W;

    logic [OFFSET_BITS-1:0] r_mem [CAPACITY];

    logic [dot_pkg::CMD_W-1:0] r_cmd;
    logic [OFFSET_BITS-1:0]    r_ofs;
    logic [dot_pkg::LEN_W-1:0] r_len;
    logic [dot_pkg::IDX_W-1:0] r_idx;
    logic [OFFSET_BITS-1:0]    r_pt;
    logic [CW-1:0]             r_walk;
    logic                      r_cmp_vld;
    logic                      r_near;
    logic [OFFSET_BITS-1:0]    r_rd_data;
    logic [CW-1:0]             r_count;
    logic                      r_full;
    logic                      r_status;
    logic                      r_hit;
    logic [OFFSET_BITS-1:0]    r_rval;

    logic [AW-1:0]          rd_addr;
    logic [OFFSET_BITS-1:0] diff_a;
    logic [OFFSET_BITS-1:0] diff_b;
    logic [OFFSET_BITS-1:0] diff;
    logic                   near_now;
    logic                   walk_more;
    logic                   idx_bad;

    assign rd_addr   = i_ctl.read_sel ? AW'(r_idx) : r_walk[AW-1:0];
    assign diff_a    = r_pt - r_rd_data;
    assign diff_b    = r_rd_data - r_pt;
    assign diff      = (r_pt > r_rd_data) ? diff_a : diff_b;
    assign near_now  = r_cmp_vld && (DW'(diff) < DW'(i_thr));
    assign walk_more = r_walk < r_count;
    assign idx_bad   = XW'(r_idx) >= XW'(r_count);

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (i_ctl.insert) begin
            r_mem[r_count[AW-1:0]] <= r_pt;
        end
    end

    // payload and search registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_cmd;
            r_ofs    <= OFFSET_BITS'(i_offset);
            r_len    <= i_length;
            r_idx    <= i_index;
            r_hit    <= 1'b0;
            r_status <= 1'b0;
            r_rval   <= '0;
        end
        if (i_ctl.scan_first || i_ctl.scan_second) begin
            r_pt      <= i_ctl.scan_first ? r_ofs : (r_ofs + OFFSET_BITS'(r_len));
            r_walk    <= '0;
            r_cmp_vld <= 1'b0;
            r_near    <= 1'b0;
        end else if (i_ctl.scan_step) begin
            r_walk    <= walk_more ? (r_walk + 1'b1) : r_walk;
            r_cmp_vld <= walk_more;
            if (near_now) begin
                r_near <= 1'b1;
            end
        end
        if (i_ctl.hit_one) begin
            r_hit <= 1'b1;
        end else if (i_ctl.hit_near) begin
            r_hit <= r_near;
        end
        if (i_ctl.read_sel) begin
            r_status <= idx_bad;
        end
        if (i_ctl.read_cap && !r_status) begin
            r_rval <= r_rd_data;
        end
        if (i_ctl.out_load) begin
            o_status      <= r_status;
            o_full_redraw <= r_full;
            o_count       <= dot_pkg::COUNT_W'(r_count);
            o_hit         <= r_hit;
            o_read_value  <= dot_pkg::OUT_W'(r_rval);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full  <= 1'b1;
            r_count <= '0;
        end else if (i_ctl.set_full) begin
            r_full  <= 1'b1;
            r_count <= '0;
        end else if (i_ctl.clear_all) begin
            r_full  <= 1'b0;
            r_count <= '0;
        end else if (i_ctl.insert) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.full       = r_full;
        o_sts.len_zero   = (r_len == '0);
        o_sts.len_big    = (r_len > i_lim);
        o_sts.scan_done  = !walk_more && !r_cmp_vld;
        o_sts.near       = r_near;
        o_sts.table_full = (r_count >= CW'(CAPACITY));
    end

endmodule

FILE: hw/rtl/dot_ctrl.sv
module dot_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  dot_pkg::t_dp_sts i_sts,
    output dot_pkg::t_dp_cmd o_ctl
);

    dot_pkg::t_state r_state, n_state;
    logic            r_second, n_second;
    logic            r_out_vld, n_out_vld;
    logic            out_free;
    logic            in_acc;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign in_acc      = i_in_valid && (r_state == dot_pkg::ST_IDLE);
    assign o_in_stall  = (r_state != dot_pkg::ST_IDLE);
    assign o_out_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dot_pkg::ST_IDLE;
            r_second  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_second  <= n_second;
            r_out_vld <= n_out_vld;
        end
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_second  = r_second;
        n_out_vld = r_out_vld && i_out_stall;
        case (r_state)
            dot_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = dot_pkg::ST_DISPATCH;
                end
            end
            dot_pkg::ST_DISPATCH: begin
                n_state  = dot_pkg::ST_FINISH;
                n_second = 1'b0;
                case (i_sts.cmd)
                    dot_pkg::CMD_MARK_POINT,
                    dot_pkg::CMD_QUERY: begin
                        if (!i_sts.full) begin
                            n_state = dot_pkg::ST_SCAN;
                        end
                    end
                    dot_pkg::CMD_MARK_RANGE: begin
                        if (!i_sts.len_zero && !i_sts.len_big && !i_sts.full) begin
                            n_state  = dot_pkg::ST_SCAN;
                            n_second = 1'b1;
                        end
                    end
                    dot_pkg::CMD_READ_INDEX: begin
                        n_state = dot_pkg::ST_READ;
                    end
                    default: begin
                        n_state = dot_pkg::ST_FINISH;
                    end
                endcase
            end
            dot_pkg::ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = (i_sts.cmd == dot_pkg::CMD_QUERY) ? dot_pkg::ST_FINISH
                                                                : dot_pkg::ST_NEXT;
                end
            end
            dot_pkg::ST_NEXT: begin
                // range end is skipped once the start has forced a full redraw
                if (r_second && !i_sts.full) begin
                    n_state  = dot_pkg::ST_SCAN;
                    n_second = 1'b0;
                end else begin
                    n_state = dot_pkg::ST_FINISH;
                end
            end
            dot_pkg::ST_READ: begin
                n_state = dot_pkg::ST_FINISH;
            end
            dot_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state   = dot_pkg::ST_IDLE;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_state = dot_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_ctl = '0;
        case (r_state)
            dot_pkg::ST_IDLE: begin
                o_ctl.load = in_acc;
            end
            dot_pkg::ST_DISPATCH: begin
                case (i_sts.cmd)
                    dot_pkg::CMD_MARK_POINT: begin
                        o_ctl.scan_first = !i_sts.full;
                    end
                    dot_pkg::CMD_MARK_RANGE: begin
                        o_ctl.set_full   = !i_sts.len_zero && i_sts.len_big;
                        o_ctl.scan_first = !i_sts.len_zero && !i_sts.len_big && !i_sts.full;
                    end
                    dot_pkg::CMD_MARK_FULL: begin
                        o_ctl.set_full = 1'b1;
                    end
                    dot_pkg::CMD_CLEAR: begin
                        o_ctl.clear_all = 1'b1;
                    end
                    dot_pkg::CMD_QUERY: begin
                        o_ctl.hit_one    = i_sts.full;
                        o_ctl.scan_first = !i_sts.full;
                    end
                    dot_pkg::CMD_READ_INDEX: begin
                        o_ctl.read_sel = 1'b1;
                    end
                    default: begin
                        o_ctl.load = 1'b0;
                    end
                endcase
            end
            dot_pkg::ST_SCAN: begin
                o_ctl.scan_step = !i_sts.scan_done;
                if (i_sts.scan_done) begin
                    if (i_sts.cmd == dot_pkg::CMD_QUERY) begin
                        o_ctl.hit_near = 1'b1;
                    end else if (!i_sts.near) begin
                        o_ctl.set_full = i_sts.table_full;
                        o_ctl.insert   = !i_sts.table_full;
                    end
                end
            end
            dot_pkg::ST_NEXT: begin
                o_ctl.scan_second = r_second && !i_sts.full;
            end
            dot_pkg::ST_READ: begin
                o_ctl.read_cap = 1'b1;
            end
            dot_pkg::ST_FINISH: begin
                o_ctl.out_load = out_free;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/dirty_offset_tracker.sv
// Dirty offset tracker: a table of up to CAPACITY dirty byte offsets, a count
// and a full-redraw flag, driven by commands on the input channel.
// Input channel: i_in_valid / o_in_stall with cmd, offset, length, index.
// Output channel: o_out_valid / i_out_stall, one result beat per command
// (status, full_redraw, count, hit, read_value).
// Registers on the APB port: merge threshold at 0x0, large-range limit at 0x4.
// One command is worked at a time. Mark point and query search the table
//   once, mark range up to twice (start, then end). Commands that skip the
//   search, including all marks and queries while the full-redraw flag is
//   set, mark full, clear and undefined codes, do no table walk; read index
//   reads one entry in its read step. The search walks the table one entry
//   per cycle through the single read port of the offset store.
// Results sit in an output register; the block takes the next beat while a
// result still waits. If the receiver stalls, a finished command holds in
// its last step until the output register frees, and o_in_stall stays high.
// Reset sets the full-redraw flag, empties the table and restores the
// register defaults (threshold 64, limit 1024); store contents stay unknown.
module dirty_offset_tracker #(
    parameter int CAPACITY    = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [dot_pkg::CMD_W-1:0]        i_cmd,
    input  logic [dot_pkg::IN_OFS_W-1:0]     i_offset,
    input  logic [dot_pkg::LEN_W-1:0]        i_length,
    input  logic [dot_pkg::IDX_W-1:0]        i_index,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_status,
    output logic                             o_full_redraw,
    output logic [dot_pkg::COUNT_W-1:0]      o_count,
    output logic                             o_hit,
    output logic [dot_pkg::OUT_W-1:0]        o_read_value,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dot_pkg::APB_AW-1:0]       paddr,
    input  logic [dot_pkg::APB_DW-1:0]       pwdata,
    output logic [dot_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);

    logic [dot_pkg::CFG_W-1:0] r_thr;
    logic [dot_pkg::CFG_W-1:0] r_lim;
    logic                      cfg_wr;

    dot_pkg::t_dp_cmd ctl;
    dot_pkg::t_dp_sts sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= dot_pkg::MERGE_THR_RST;
            r_lim <= dot_pkg::RANGE_LIM_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                dot_pkg::REG_MERGE_THR: r_thr <= pwdata[dot_pkg::CFG_W-1:0];
                dot_pkg::REG_RANGE_LIM: r_lim <= pwdata[dot_pkg::CFG_W-1:0];
                default: r_thr <= r_thr;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dot_pkg::REG_MERGE_THR: prdata = dot_pkg::APB_DW'(r_thr);
            dot_pkg::REG_RANGE_LIM: prdata = dot_pkg::APB_DW'(r_lim);
            default:                prdata = '0;
        endcase
    end

    dot_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    dot_dpath #(
        .CAPACITY    (CAPACITY),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_cmd         (i_cmd),
        .i_offset      (i_offset),
        .i_length      (i_length),
        .i_index       (i_index),
        .i_thr         (r_thr),
        .i_lim         (r_lim),
        .o_status      (o_status),
        .o_full_redraw (o_full_redraw),
        .o_count       (o_count),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value)
    );

endmodule
